[rtl/c2p_pkg.sv]
`timescale 1ns / 1ps

package c2p_pkg;

	// Field widths
	localparam int COORD_W  = 16;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int RADIUS_W = 17;
	localparam int ANGLE_W  = 16;

	// Default number of CORDIC micro-rotations
	localparam int ITERATIONS_DEF = 16;

	// CORDIC datapath formats
	localparam int XY_SCALE = 12;
	localparam int XY_W     = 32;
	localparam int ANG_FRAC = 20;
	localparam int Z_W      = 24;

	// Square root datapath: one result bit per stage
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int ROOT_W     = SQ_W / 2;
	localparam int REM_W      = ROOT_W + 3;
	localparam int SQRT_STEPS = ROOT_W;

	localparam logic signed [Z_W-1:0] HALF_PI_Q20 = 24'sd1647099;
	localparam logic signed [Z_W-1:0] PI_Q13      = 24'sd25736;
	localparam int                    ANG_SHIFT   = ANG_FRAC - 13;
	localparam logic signed [Z_W-1:0] ANG_ROUND   = Z_W'(1) << (ANG_FRAC - 14);

	localparam logic signed [Z_W-1:0] ATAN_SMALL [8] = '{
		24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
		24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192
	};

	// Data carried down the rotation / root pipeline
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   zero;
		logic [SQ_W-1:0]        sq;
		logic [REM_W-1:0]       rem;
		logic [ROOT_W-1:0]      root;
	} core_t;

	// atan(2^-i) in Q20
	function automatic logic signed [Z_W-1:0] atan_q20(input int i);
		logic signed [Z_W-1:0] r;
		if (i < 8) begin
			r = ATAN_SMALL[i[2:0]];
		end else if (i > ANG_FRAC) begin
			r = '0;
		end else begin
			r = {{(Z_W-1){1'b0}}, 1'b1} << (ANG_FRAC - i);
		end
		return r;
	endfunction

endpackage

[rtl/c2p_if.sv]
`timescale 1ns / 1ps

// Point pair channel
interface c2p_in_if;
	import c2p_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] start_x;
	logic signed [COORD_W-1:0] start_y;
	logic signed [COORD_W-1:0] end_x;
	logic signed [COORD_W-1:0] end_y;

	modport source(output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// Polar result channel
interface c2p_out_if;
	import c2p_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [RADIUS_W-1:0]       radius;
	logic signed [ANGLE_W-1:0] angle;

	modport source(output valid, radius, angle, input ready);
	modport sink(input valid, radius, angle, output ready);
endinterface

[rtl/c2p_front.sv]
`timescale 1ns / 1ps

module c2p_front (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [c2p_pkg::COORD_W-1:0] start_x,
	input  logic signed [c2p_pkg::COORD_W-1:0] start_y,
	input  logic signed [c2p_pkg::COORD_W-1:0] end_x,
	input  logic signed [c2p_pkg::COORD_W-1:0] end_y,
	output c2p_pkg::core_t                     d
);
	import c2p_pkg::*;

	logic signed [DIFF_W-1:0]   dx_s1, dy_s1;
	logic signed [2*DIFF_W-1:0] sqx, sqy;
	logic signed [DIFF_W-1:0]   px, py;
	logic signed [Z_W-1:0]      pz;
	logic [SQ_W-1:0]            sqx_s2, sqy_s2;
	logic signed [DIFF_W-1:0]   px_s2, py_s2;
	logic signed [Z_W-1:0]      pz_s2;
	logic                       zero_s2;
	core_t                      d_s3;

	// Stage 1: difference vector
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
			dy_s1 <= {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
		end
	end

	assign sqx = dx_s1 * dx_s1;
	assign sqy = dy_s1 * dy_s1;

	// Fold the left half-plane into the right one
	always_comb begin
		if (dx_s1[DIFF_W-1]) begin
			if (!dy_s1[DIFF_W-1]) begin
				px = dy_s1;
				py = -dx_s1;
				pz = HALF_PI_Q20;
			end else begin
				px = -dy_s1;
				py = dx_s1;
				pz = -HALF_PI_Q20;
			end
		end else begin
			px = dx_s1;
			py = dy_s1;
			pz = '0;
		end
	end

	// Stage 2: squares and pre-rotation
	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2  <= unsigned'(sqx);
			sqy_s2  <= unsigned'(sqy);
			px_s2   <= px;
			py_s2   <= py;
			pz_s2   <= pz;
			zero_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
		end
	end

	// Stage 3: sum of squares, scaled CORDIC start vector
	always_ff @(posedge clk) begin
		if (en) begin
			d_s3.sq   <= sqx_s2 + sqy_s2;
			d_s3.x    <= {{(XY_W-DIFF_W-XY_SCALE){px_s2[DIFF_W-1]}}, px_s2,
				{XY_SCALE{1'b0}}};
			d_s3.y    <= {{(XY_W-DIFF_W-XY_SCALE){py_s2[DIFF_W-1]}}, py_s2,
				{XY_SCALE{1'b0}}};
			d_s3.z    <= pz_s2;
			d_s3.zero <= zero_s2;
			d_s3.rem  <= '0;
			d_s3.root <= '0;
		end
	end

	assign d = d_s3;

endmodule

[rtl/c2p_stage.sv]
`timescale 1ns / 1ps

module c2p_stage #(
	parameter int STEP       = 0,
	parameter int ITERATIONS = c2p_pkg::ITERATIONS_DEF
) (
	input  logic           clk,
	input  logic           en,
	input  c2p_pkg::core_t d,
	output c2p_pkg::core_t q
);
	import c2p_pkg::*;

	localparam bit                    DO_ROT  = (STEP < ITERATIONS);
	localparam bit                    DO_SQRT = (STEP < SQRT_STEPS);
	localparam logic signed [Z_W-1:0] ATAN_K  = atan_q20(STEP);

	logic signed [XY_W-1:0] xin, yin, xs, ys;
	logic [REM_W-1:0]       trial_rem, trial_sub;
	core_t                  nxt;
	core_t                  res_s1;

	assign xin = d.x;
	assign yin = d.y;
	assign xs  = xin >>> STEP;
	assign ys  = yin >>> STEP;

	// Bring down the next two radicand bits and try the next root bit
	assign trial_rem = {d.rem[REM_W-3:0], d.sq[SQ_W-1 -: 2]};
	assign trial_sub = {{(REM_W-ROOT_W-2){1'b0}}, d.root, 2'b01};

	always_comb begin
		nxt = d;
		// One micro-rotation toward the x axis
		if (DO_ROT) begin
			if (!yin[XY_W-1]) begin
				nxt.x = xin + ys;
				nxt.y = yin - xs;
				nxt.z = d.z + ATAN_K;
			end else begin
				nxt.x = xin - ys;
				nxt.y = yin + xs;
				nxt.z = d.z - ATAN_K;
			end
		end
		// One bit of the restoring square root
		if (DO_SQRT) begin
			nxt.sq = {d.sq[SQ_W-3:0], 2'b00};
			if (trial_rem >= trial_sub) begin
				nxt.rem  = trial_rem - trial_sub;
				nxt.root = {d.root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem  = trial_rem;
				nxt.root = {d.root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1 <= nxt;
		end
	end

	assign q = res_s1;

endmodule

[rtl/c2p_back.sv]
`timescale 1ns / 1ps

module c2p_back (
	input  logic                               clk,
	input  logic                               en,
	input  c2p_pkg::core_t                     d,
	output logic [c2p_pkg::RADIUS_W-1:0]       radius,
	output logic signed [c2p_pkg::ANGLE_W-1:0] angle
);
	import c2p_pkg::*;

	logic signed [Z_W-1:0]     zsum, zr;
	logic signed [ANGLE_W-1:0] ang;
	logic [RADIUS_W-1:0]       rad;
	logic [RADIUS_W-1:0]       radius_s1;
	logic signed [ANGLE_W-1:0] angle_s1;

	// Round the Q20 angle half up to Q13, clamp to +-pi
	assign zsum = d.z + ANG_ROUND;
	assign zr   = zsum >>> ANG_SHIFT;

	always_comb begin
		if (d.zero) begin
			ang = '0;
		end else if (zr > PI_Q13) begin
			ang = PI_Q13[ANGLE_W-1:0];
		end else if (zr < -PI_Q13) begin
			ang = ANGLE_W'(-PI_Q13);
		end else begin
			ang = zr[ANGLE_W-1:0];
		end
	end

	// Round the root to nearest: remainder above root means past the half
	assign rad = ({{(REM_W-ROOT_W){1'b0}}, d.root} < d.rem) ? d.root + 1'b1 : d.root;

	always_ff @(posedge clk) begin
		if (en) begin
			radius_s1 <= rad;
			angle_s1  <= ang;
		end
	end

	assign radius = radius_s1;
	assign angle  = angle_s1;

endmodule

[rtl/cartesian_to_polar.sv]
`timescale 1ns / 1ps

// Cartesian to polar conversion of the vector from a start to an end point.
// Channel points (sink): start_x, start_y, end_x, end_y, signed Q8.8.
// Channel polar (source): radius, unsigned Q9.8, rounded to nearest;
// angle, signed Q3.13 radians in -pi..pi, zero for a zero-length vector.
// A transfer happens on a rising edge with valid and ready both high.
// Pipeline: three front stages form the difference, the squares and their
// sum; then one core stage per CORDIC micro-rotation or square root bit,
// whichever there are more of, each stage doing one of each while they
// last; then one rounding stage.
// Throughput: one transfer per cycle while the skid register is empty, set by the fully unrolled pipeline.
// Stall: when polar is not ready, one finished result is parked in a skid
// register and the pipeline keeps moving for that cycle; once the skid
// register is full the whole pipeline holds and points.ready drops.
// Reset (arst_n low) empties the pipeline and the skid register; the block
// keeps no other state.
module cartesian_to_polar #(
	parameter int ITERATIONS = c2p_pkg::ITERATIONS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	c2p_in_if.sink    points,
	c2p_out_if.source polar
);
	import c2p_pkg::*;

	localparam int CORE_N = (ITERATIONS > SQRT_STEPS) ? ITERATIONS : SQRT_STEPS;
	localparam int PIPE_N = CORE_N + 4;

	logic                      en;
	logic [PIPE_N-1:0]         vld_q;
	logic                      skid_full_q;
	logic [RADIUS_W-1:0]       skid_radius_q, pipe_radius;
	logic signed [ANGLE_W-1:0] skid_angle_q, pipe_angle;
	core_t                     core_d [0:CORE_N];

	// Pipeline moves whenever the skid register is free
	assign en           = !skid_full_q;
	assign points.ready = en;

	c2p_front u_front (
		.clk     (clk),
		.en      (en),
		.start_x (points.start_x),
		.start_y (points.start_y),
		.end_x   (points.end_x),
		.end_y   (points.end_y),
		.d       (core_d[0])
	);

	for (genvar k = 0; k < CORE_N; k++) begin : g_stage
		c2p_stage #(
			.STEP       (k),
			.ITERATIONS (ITERATIONS)
		) u_stage (
			.clk (clk),
			.en  (en),
			.d   (core_d[k]),
			.q   (core_d[k+1])
		);
	end

	c2p_back u_back (
		.clk    (clk),
		.en     (en),
		.d      (core_d[CORE_N]),
		.radius (pipe_radius),
		.angle  (pipe_angle)
	);

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_N-2:0], points.valid};
		end
	end

	// Skid control: park the last stage's result when the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (polar.ready) begin
				skid_full_q <= 1'b0;
			end
		end else if (vld_q[PIPE_N-1] && !polar.ready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			skid_radius_q <= pipe_radius;
			skid_angle_q  <= pipe_angle;
		end
	end

	// Older parked result goes first
	assign polar.valid  = skid_full_q || vld_q[PIPE_N-1];
	assign polar.radius = skid_full_q ? skid_radius_q : pipe_radius;
	assign polar.angle  = skid_full_q ? skid_angle_q : pipe_angle;

endmodule
